/* hdl/stereo_eye_pose_offset_assert.svh */
// assertion macros for the stereo eye pose offset block
// no dependencies; taken in by the top level through include
`ifndef STEREO_EYE_POSE_OFFSET_ASSERT_SVH
`define STEREO_EYE_POSE_OFFSET_ASSERT_SVH
`ifndef ASSERT_OFF
`define SEO_ASSERT_IMPLY(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("implication check failed");
`define SEO_ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("next cycle check failed");
`else
`define SEO_ASSERT_IMPLY(label, clk, rst_n, a, b)
`define SEO_ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

/* hdl/seo_pkg.sv */
// shared constants and types for the stereo eye pose offset block
// no dependencies
package seo_pkg;
	localparam int COORD_W   = 32;
	localparam int REG_W     = 31;
	localparam int VEC_W     = 66;
	localparam int NBITS_W   = 7;
	localparam int NORM_BITS = 30;
	localparam int SUMSQ_W   = 62;
	localparam int ROOT_W    = 31;
	localparam int DEN_W     = 32;
	localparam int NUM_W     = 62;
	localparam int QUO_W     = 32;
	localparam int RES_W     = 33;
	localparam int SQRT_LAT  = 32;
	localparam int DIV_LAT   = 32;
	localparam int DIR_LAT   = 6 + SQRT_LAT + 1 + DIV_LAT + 1;
	localparam int FE_LAT    = 3;
	localparam int TOT_LAT   = FE_LAT + DIR_LAT + 1;

	typedef enum logic {
		REG_EYE_SEP = 1'b0,
		REG_CONV    = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic valid;
		logic zero;
	} dir_status_t;
endpackage

/* hdl/seo_sqrt_pipe.sv */
// pipelined floor square root, one result bit per stage
// depends on seo_pkg
module seo_sqrt_pipe (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           valid_in,
	input  logic [seo_pkg::SUMSQ_W-1:0]    x_in,
	output logic                           valid_out,
	output logic [seo_pkg::ROOT_W-1:0]     root
);
	logic [63:0] rem_s [seo_pkg::SQRT_LAT];
	logic [63:0] res_s [seo_pkg::SQRT_LAT];
	logic        vld_s [seo_pkg::SQRT_LAT];

	for (genvar k = 0; k < seo_pkg::SQRT_LAT; k++) begin : g_stage
		localparam int SH = 2 * (seo_pkg::SQRT_LAT - 1 - k);
		logic [63:0] rem_in, res_in, bit_c, trial, rem_nx, res_nx;
		logic        vld_in;
		if (k == 0) begin : g_head
			assign rem_in = 64'(x_in);
			assign res_in = '0;
			assign vld_in = valid_in;
		end else begin : g_tail
			assign rem_in = rem_s[k-1];
			assign res_in = res_s[k-1];
			assign vld_in = vld_s[k-1];
		end
		always_comb begin
			bit_c = 64'(1) << SH;
			trial = res_in + bit_c;
			if (rem_in >= trial) begin
				rem_nx = rem_in - trial;
				res_nx = (res_in >> 1) + bit_c;
			end else begin
				rem_nx = rem_in;
				res_nx = res_in >> 1;
			end
		end
		always_ff @(posedge clk) begin
			rem_s[k] <= rem_nx;
			res_s[k] <= res_nx;
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else begin
				vld_s[k] <= vld_in;
			end
		end
	end

	assign valid_out = vld_s[seo_pkg::SQRT_LAT-1];
	assign root      = seo_pkg::ROOT_W'(res_s[seo_pkg::SQRT_LAT-1]);
endmodule

/* hdl/seo_div_pipe.sv */
// pipelined restoring divider, one quotient bit per stage
// depends on seo_pkg
module seo_div_pipe (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        valid_in,
	input  logic [seo_pkg::NUM_W-1:0]   num,
	input  logic [seo_pkg::DEN_W-1:0]   den,
	output logic                        valid_out,
	output logic [seo_pkg::QUO_W-1:0]   quo
);
	logic [63:0]                     rem_s [seo_pkg::DIV_LAT];
	logic [seo_pkg::DEN_W-1:0]       den_s [seo_pkg::DIV_LAT];
	logic [seo_pkg::QUO_W-1:0]       quo_s [seo_pkg::DIV_LAT];
	logic                            vld_s [seo_pkg::DIV_LAT];

	for (genvar k = 0; k < seo_pkg::DIV_LAT; k++) begin : g_stage
		localparam int J = seo_pkg::DIV_LAT - 1 - k;
		logic [63:0]               rem_in, dsh, rem_nx;
		logic [seo_pkg::DEN_W-1:0] den_in;
		logic [seo_pkg::QUO_W-1:0] quo_in, quo_nx;
		logic                      vld_in;
		if (k == 0) begin : g_head
			assign rem_in = 64'(num);
			assign den_in = den;
			assign quo_in = '0;
			assign vld_in = valid_in;
		end else begin : g_tail
			assign rem_in = rem_s[k-1];
			assign den_in = den_s[k-1];
			assign quo_in = quo_s[k-1];
			assign vld_in = vld_s[k-1];
		end
		always_comb begin
			dsh    = 64'(den_in) << J;
			rem_nx = rem_in;
			quo_nx = quo_in;
			if (rem_in >= dsh) begin
				rem_nx    = rem_in - dsh;
				quo_nx[J] = 1'b1;
			end
		end
		always_ff @(posedge clk) begin
			rem_s[k] <= rem_nx;
			den_s[k] <= den_in;
			quo_s[k] <= quo_nx;
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else begin
				vld_s[k] <= vld_in;
			end
		end
	end

	assign valid_out = vld_s[seo_pkg::DIV_LAT-1];
	assign quo       = quo_s[seo_pkg::DIV_LAT-1];
endmodule

/* hdl/seo_dir_unit.sv */
// scales a vector's direction to a given length, or half of it: normalize, root, divide
// depends on seo_pkg, seo_sqrt_pipe, seo_div_pipe
module seo_dir_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	input  logic signed [seo_pkg::VEC_W-1:0]  vec [3],
	input  logic [seo_pkg::REG_W-1:0]         len,
	input  logic                              halve,
	output seo_pkg::dir_status_t              out_st,
	output logic signed [seo_pkg::RES_W-1:0]  res [3]
);
	localparam int PROD_W = seo_pkg::NORM_BITS + seo_pkg::REG_W;
	localparam int SQ_W   = 2 * seo_pkg::NORM_BITS;
	localparam int WIDE_W = seo_pkg::VEC_W + seo_pkg::NORM_BITS;

	logic [seo_pkg::VEC_W-1:0]     m_s1 [3], m_s2 [3], m_s3 [3];
	logic [2:0]                    neg_s1, neg_s2, neg_s3, neg_s4, neg_s5, neg_s6, neg_s7;
	logic [seo_pkg::VEC_W-1:0]     orv_s2;
	logic [seo_pkg::NBITS_W-1:0]   n_s3, n_c;
	logic [seo_pkg::NORM_BITS-1:0] s_s4 [3];
	logic                          zero_s4, zero_s5, zero_s6, zero_s7;
	logic [SQ_W-1:0]               sq_s5 [3];
	logic [PROD_W-1:0]             prod_s5 [3], prod_s6 [3];
	logic [seo_pkg::SUMSQ_W-1:0]   sum_s6;
	logic [PROD_W-1:0]             prod_d [seo_pkg::SQRT_LAT][3];
	logic [2:0]                    neg_d [seo_pkg::SQRT_LAT];
	logic                          zero_d [seo_pkg::SQRT_LAT];
	logic [seo_pkg::DEN_W-1:0]     den_s7, den_c;
	logic [seo_pkg::NUM_W-1:0]     num_s7 [3];
	logic [2:0]                    neg_e [seo_pkg::DIV_LAT];
	logic                          zero_e [seo_pkg::DIV_LAT];
	logic [seo_pkg::QUO_W-1:0]     quo [3];
	logic [seo_pkg::ROOT_W-1:0]    root;
	logic                          root_valid, quo_valid;
	logic                          valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6;
	logic                          valid_s7, valid_s8;
	logic                          zero_s8;
	logic signed [seo_pkg::RES_W-1:0] res_s8 [3];

	always_comb begin
		n_c = '0;
		for (int b = 0; b < seo_pkg::VEC_W; b++) begin
			if (orv_s2[b]) begin
				n_c = seo_pkg::NBITS_W'(b + 1);
			end
		end
	end

	always_comb begin
		den_c = halve ? {root, 1'b0} : {1'b0, root};
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			neg_s1[i] <= vec[i][seo_pkg::VEC_W-1];
			m_s1[i]   <= vec[i][seo_pkg::VEC_W-1] ? seo_pkg::VEC_W'(-vec[i])
			                                       : seo_pkg::VEC_W'(vec[i]);
			m_s2[i]   <= m_s1[i];
			m_s3[i]   <= m_s2[i];
			s_s4[i]   <= seo_pkg::NORM_BITS'((WIDE_W'(m_s3[i]) << seo_pkg::NORM_BITS) >> n_s3);
			sq_s5[i]  <= SQ_W'(s_s4[i]) * SQ_W'(s_s4[i]);
			prod_s5[i] <= PROD_W'(PROD_W'(s_s4[i]) * PROD_W'(len));
			prod_s6[i] <= prod_s5[i];
			num_s7[i] <= seo_pkg::NUM_W'(prod_d[seo_pkg::SQRT_LAT-1][i])
			           + seo_pkg::NUM_W'(den_c >> 1);
		end
		orv_s2  <= m_s1[0] | m_s1[1] | m_s1[2];
		neg_s2  <= neg_s1;
		neg_s3  <= neg_s2;
		n_s3    <= n_c;
		neg_s4  <= neg_s3;
		zero_s4 <= (n_s3 == '0);
		neg_s5  <= neg_s4;
		zero_s5 <= zero_s4;
		sum_s6  <= seo_pkg::SUMSQ_W'(sq_s5[0]) + seo_pkg::SUMSQ_W'(sq_s5[1])
		         + seo_pkg::SUMSQ_W'(sq_s5[2]);
		neg_s6  <= neg_s5;
		zero_s6 <= zero_s5;
		den_s7  <= den_c;
		neg_s7  <= neg_d[seo_pkg::SQRT_LAT-1];
		zero_s7 <= zero_d[seo_pkg::SQRT_LAT-1];
		// sideband alongside the root stages
		for (int k = seo_pkg::SQRT_LAT - 1; k > 0; k--) begin
			prod_d[k] <= prod_d[k-1];
			neg_d[k]  <= neg_d[k-1];
			zero_d[k] <= zero_d[k-1];
		end
		prod_d[0] <= prod_s6;
		neg_d[0]  <= neg_s6;
		zero_d[0] <= zero_s6;
		// sideband alongside the divider stages
		for (int k = seo_pkg::DIV_LAT - 1; k > 0; k--) begin
			neg_e[k]  <= neg_e[k-1];
			zero_e[k] <= zero_e[k-1];
		end
		neg_e[0]  <= neg_s7;
		zero_e[0] <= zero_s7;
		zero_s8   <= zero_e[seo_pkg::DIV_LAT-1];
		for (int i = 0; i < 3; i++) begin
			if (zero_e[seo_pkg::DIV_LAT-1]) begin
				res_s8[i] <= '0;
			end else if (neg_e[seo_pkg::DIV_LAT-1][i]) begin
				res_s8[i] <= -$signed(seo_pkg::RES_W'(quo[i]));
			end else begin
				res_s8[i] <= $signed(seo_pkg::RES_W'(quo[i]));
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
			valid_s8 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
			valid_s7 <= root_valid;
			valid_s8 <= quo_valid;
		end
	end

	seo_sqrt_pipe u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_in  (valid_s6),
		.x_in      (sum_s6),
		.valid_out (root_valid),
		.root      (root)
	);

	seo_div_pipe u_div0 (
		.clk (clk), .arst_n (arst_n), .valid_in (valid_s7),
		.num (num_s7[0]), .den (den_s7), .valid_out (quo_valid), .quo (quo[0])
	);
	seo_div_pipe u_div1 (
		.clk (clk), .arst_n (arst_n), .valid_in (valid_s7),
		.num (num_s7[1]), .den (den_s7), .valid_out (), .quo (quo[1])
	);
	seo_div_pipe u_div2 (
		.clk (clk), .arst_n (arst_n), .valid_in (valid_s7),
		.num (num_s7[2]), .den (den_s7), .valid_out (), .quo (quo[2])
	);

	assign out_st.valid = valid_s8;
	assign out_st.zero  = zero_s8;
	assign res          = res_s8;
endmodule

/* hdl/stereo_eye_pose_offset.sv */
// top level of the stereo eye pose offset block: apb registers, cross product, output sums
// depends on seo_pkg, seo_dir_unit and stereo_eye_pose_offset_assert.svh
//
//  channel    handshake                     payload
//  -------    ---------                     -------
//  pose in    start high, busy low          pos_*, tar_*, up_*
//  result     done strobe, one cycle        right_eye_*, left_eye_*, focus_*, degenerate
//  config     apb write, psel+penable       eye_separation (0x0), convergence_distance (0x4)
//
// a new pose can be taken every cycle; busy never rises
// each result's path from its pose runs mostly through the 32-stage root
// and the 32-stage quotient pipes of the two direction units
// reset clears only valid bits and config registers; data regs carry no reset
// the receiver cannot stall, so the pipeline advances every cycle
`include "stereo_eye_pose_offset_assert.svh"
module stereo_eye_pose_offset (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [31:0] pos_z,
	input  logic signed [31:0] tar_x,
	input  logic signed [31:0] tar_y,
	input  logic signed [31:0] tar_z,
	input  logic signed [31:0] up_x,
	input  logic signed [31:0] up_y,
	input  logic signed [31:0] up_z,
	output logic               done,
	output logic signed [31:0] right_eye_x,
	output logic signed [31:0] right_eye_y,
	output logic signed [31:0] right_eye_z,
	output logic signed [31:0] left_eye_x,
	output logic signed [31:0] left_eye_y,
	output logic signed [31:0] left_eye_z,
	output logic signed [31:0] focus_x,
	output logic signed [31:0] focus_y,
	output logic signed [31:0] focus_z,
	output logic               degenerate
);
	localparam int D_W = seo_pkg::COORD_W + 1;
	localparam int P_W = seo_pkg::COORD_W + D_W;
	localparam int S_W = seo_pkg::COORD_W + 2;

	// configuration registers
	logic [seo_pkg::REG_W-1:0] eye_sep_q, conv_dist_q;
	seo_pkg::reg_idx_t          reg_idx;
	logic                       cfg_wr;

	// front pipeline
	logic                               valid_s1, valid_s2, valid_s3;
	logic signed [seo_pkg::COORD_W-1:0] pos_s1 [3], pos_s2 [3], pos_s3 [3];
	logic signed [seo_pkg::COORD_W-1:0] up_s1 [3];
	logic signed [D_W-1:0]              d_s1 [3], view_s2 [3];
	logic signed [P_W-1:0]              pa_s2 [3], pb_s2 [3];
	logic signed [seo_pkg::VEC_W-1:0]   side_s3 [3], view_s3 [3];

	// position delay alongside the direction units
	logic signed [seo_pkg::COORD_W-1:0] pos_d [seo_pkg::DIR_LAT][3];

	seo_pkg::dir_status_t               side_st, view_st;
	logic signed [seo_pkg::RES_W-1:0]   half_side [3], fwd [3];
	logic signed [seo_pkg::COORD_W-1:0] pos_o [3];

	function automatic logic signed [31:0] sat(input logic signed [S_W-1:0] v);
		logic signed [S_W-1:0] hi, lo;
		hi = S_W'(32'sh7fffffff);
		lo = -hi - S_W'(1);
		if (v > hi) begin
			return 32'sh7fffffff;
		end else if (v < lo) begin
			return 32'sh80000000;
		end
		return 32'(v);
	endfunction

	assign busy    = 1'b0;
	assign pready  = 1'b1;
	assign reg_idx = seo_pkg::reg_idx_t'(paddr[2]);
	assign cfg_wr  = psel && penable && pwrite && pready;

	// register read mux
	always_comb begin
		unique case (reg_idx)
			seo_pkg::REG_EYE_SEP: prdata = {1'b0, eye_sep_q};
			seo_pkg::REG_CONV:    prdata = {1'b0, conv_dist_q};
			default:              prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eye_sep_q   <= seo_pkg::REG_W'(65536);
			conv_dist_q <= seo_pkg::REG_W'(655360);
		end else if (cfg_wr) begin
			unique case (reg_idx)
				seo_pkg::REG_EYE_SEP: eye_sep_q   <= pwdata[seo_pkg::REG_W-1:0];
				seo_pkg::REG_CONV:    conv_dist_q <= pwdata[seo_pkg::REG_W-1:0];
				default: ;
			endcase
		end
	end

	// s1: pos minus tar; s2: cross product terms; s3: side difference
	always_ff @(posedge clk) begin
		pos_s1[0] <= pos_x;
		pos_s1[1] <= pos_y;
		pos_s1[2] <= pos_z;
		up_s1[0]  <= up_x;
		up_s1[1]  <= up_y;
		up_s1[2]  <= up_z;
		d_s1[0]   <= D_W'(pos_x) - D_W'(tar_x);
		d_s1[1]   <= D_W'(pos_y) - D_W'(tar_y);
		d_s1[2]   <= D_W'(pos_z) - D_W'(tar_z);
		pa_s2[0]  <= P_W'(up_s1[1]) * P_W'(d_s1[2]);
		pb_s2[0]  <= P_W'(up_s1[2]) * P_W'(d_s1[1]);
		pa_s2[1]  <= P_W'(up_s1[2]) * P_W'(d_s1[0]);
		pb_s2[1]  <= P_W'(up_s1[0]) * P_W'(d_s1[2]);
		pa_s2[2]  <= P_W'(up_s1[0]) * P_W'(d_s1[1]);
		pb_s2[2]  <= P_W'(up_s1[1]) * P_W'(d_s1[0]);
		for (int i = 0; i < 3; i++) begin
			view_s2[i] <= -d_s1[i];
			pos_s2[i]  <= pos_s1[i];
			pos_s3[i]  <= pos_s2[i];
			side_s3[i] <= seo_pkg::VEC_W'(pa_s2[i]) - seo_pkg::VEC_W'(pb_s2[i]);
			view_s3[i] <= seo_pkg::VEC_W'(view_s2[i]);
		end
		for (int k = seo_pkg::DIR_LAT - 1; k > 0; k--) begin
			pos_d[k] <= pos_d[k-1];
		end
		pos_d[0] <= pos_s3;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			done     <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			done     <= side_st.valid;
		end
	end

	// half side vector, scaled by eye separation
	seo_dir_unit u_side (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (valid_s3),
		.vec      (side_s3),
		.len      (eye_sep_q),
		.halve    (1'b1),
		.out_st   (side_st),
		.res      (half_side)
	);

	// view direction, scaled by convergence distance
	seo_dir_unit u_view (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (valid_s3),
		.vec      (view_s3),
		.len      (conv_dist_q),
		.halve    (1'b0),
		.out_st   (view_st),
		.res      (fwd)
	);

	assign pos_o = pos_d[seo_pkg::DIR_LAT-1];

	// output stage: eye offsets and focus point, saturated
	always_ff @(posedge clk) begin
		right_eye_x <= sat(S_W'(pos_o[0]) - S_W'(half_side[0]));
		right_eye_y <= sat(S_W'(pos_o[1]) - S_W'(half_side[1]));
		right_eye_z <= sat(S_W'(pos_o[2]) - S_W'(half_side[2]));
		left_eye_x  <= sat(S_W'(pos_o[0]) + S_W'(half_side[0]));
		left_eye_y  <= sat(S_W'(pos_o[1]) + S_W'(half_side[1]));
		left_eye_z  <= sat(S_W'(pos_o[2]) + S_W'(half_side[2]));
		focus_x     <= sat(S_W'(pos_o[0]) + S_W'(fwd[0]));
		focus_y     <= sat(S_W'(pos_o[1]) + S_W'(fwd[1]));
		focus_z     <= sat(S_W'(pos_o[2]) + S_W'(fwd[2]));
		degenerate  <= side_st.zero || view_st.zero;
	end

	// every result traces back to a transaction taken a fixed latency earlier
	`SEO_ASSERT_IMPLY(a_done_latency, clk, arst_n, done,
		$past(start && !busy, seo_pkg::TOT_LAT))
	// both direction units stay in lockstep
	`SEO_ASSERT_IMPLY(a_units_aligned, clk, arst_n, 1'b1, side_st.valid == view_st.valid)
	// a zero side vector puts both eyes on the camera position
	`SEO_ASSERT_NEXT(a_zero_side_eyes, clk, arst_n, side_st.valid && side_st.zero,
		right_eye_x == left_eye_x && right_eye_y == left_eye_y && right_eye_z == left_eye_z)
endmodule
